@@ src/tfde_pkg.sv @@
// Shared types and constants for the tricolor framebuffer draw engine.
package tfde_pkg;

   localparam int MaxWidth  = 512;
   localparam int MaxHeight = 512;
   localparam int RowBytesMax = (MaxWidth + 7) / 8;
   localparam int PlaneDepth = RowBytesMax * MaxHeight;
   localparam int AddrW = $clog2(PlaneDepth);
   localparam int CoordW = 10;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 10;

   localparam logic [CsrIdxW-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_FLIP   = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_RED    = 2'd3;

   localparam logic [2:0] OP_SET   = 3'd0;
   localparam logic [2:0] OP_GET   = 3'd1;
   localparam logic [2:0] OP_FILL  = 3'd2;
   localparam logic [2:0] OP_LINE  = 3'd3;
   localparam logic [2:0] OP_RECT  = 3'd4;
   localparam logic [2:0] OP_CLEAR = 3'd5;

   localparam logic [1:0] PAINT_WHITE = 2'd0;
   localparam logic [1:0] PAINT_BLACK = 2'd1;
   localparam logic [1:0] PAINT_RED   = 2'd2;

   typedef struct packed {
      logic [2:0]        operation;
      logic [CoordW-1:0] start_x;
      logic [CoordW-1:0] start_y;
      logic [CoordW-1:0] end_x;
      logic [CoordW-1:0] end_y;
      logic [1:0]        paint;
   } req_type;

   typedef struct packed {
      logic [1:0] read_color;
      logic       was_read;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_cmd;    // capture a command
      logic seg_load;    // load line segment endpoints
      logic [1:0] seg_sel;
      logic line_step;   // plot current point then advance
      logic fill_init;
      logic fill_step;
      logic clr_step;    // write one byte of the mono plane, and of red if enabled
      logic clr_init;
      logic get_issue;
      logic plot_pt;     // single pixel set
      logic wipe_step;   // write one byte of the whole planes after reset
   } dp_cmd_type;

   typedef struct packed {
      logic line_done;   // current point is the endpoint
      logic fill_done;
      logic fill_empty;
      logic clr_done;
      logic clr_empty;
      logic rmw_busy;    // a read-modify-write still in flight
      logic wipe_done;   // the reset sweep is at its last byte
   } dp_sts_type;

endpackage

@@ src/tfde_datapath.sv @@
// Datapath: coordinate units, plane memories with read-modify-write and readback.
module tfde_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  tfde_pkg::req_type     req_in,
   input  logic [9:0]            csr_w,
   input  logic [9:0]            csr_h,
   input  logic                  csr_flip,
   input  logic                  csr_red,
   input  tfde_pkg::dp_cmd_type  cmd,
   output tfde_pkg::dp_sts_type  sts,
   output logic [1:0]            get_color
);
   localparam int AW = tfde_pkg::AddrW;
   localparam logic [1:0] PAINT_MAXV = tfde_pkg::PAINT_RED;

   tfde_pkg::req_type req_ff;
   // Effective size, saturated.
   logic [9:0] ew, eh;
   assign ew = (csr_w > 10'(tfde_pkg::MaxWidth)) ? 10'(tfde_pkg::MaxWidth) : csr_w;
   assign eh = (csr_h > 10'(tfde_pkg::MaxHeight)) ? 10'(tfde_pkg::MaxHeight) : csr_h;
   logic [7:0] rbytes;
   assign rbytes = 8'((11'(ew) + 11'd7) >> 3);

   // Line walker state.
   logic signed [11:0] x_ff, y_ff, x1_ff, y1_ff, dx_ff, dy_ff, err_ff;
   logic sx_ff, sy_ff;
   // Fill state.
   logic [9:0] fx_ff, fy_ff, fx0_ff, fx1_ff, fy1_ff;
   // Clear state.
   logic [AW:0] cidx_ff, csize_ff;
   // Reset sweep address.
   logic [AW-1:0] wipe_ff;

   // Pixel request into the plot pipeline.
   logic       pv;
   logic [9:0] px, py;
   logic [1:0] ppaint;

   always_ff @(posedge clock) begin
      if (cmd.load_cmd) begin
         req_ff <= req_in;
      end
   end

   // Segment endpoint selection for line and outline.
   logic [9:0] a_x, a_y, b_x, b_y;
   always_comb begin
      a_x = req_ff.start_x; a_y = req_ff.start_y;
      b_x = req_ff.end_x;   b_y = req_ff.end_y;
      case (cmd.seg_sel)
         2'd0: begin
            if (req_ff.operation == tfde_pkg::OP_RECT) b_y = req_ff.start_y;
         end
         2'd1: begin a_y = req_ff.end_y; end
         2'd2: begin b_x = req_ff.start_x; end
         default: begin a_x = req_ff.end_x; end
      endcase
   end

   logic signed [12:0] e2;
   assign e2 = {err_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.seg_load) begin
         x_ff  <= 12'(a_x); y_ff <= 12'(a_y);
         x1_ff <= 12'(b_x); y1_ff <= 12'(b_y);
         dx_ff <= (b_x >= a_x) ? 12'(b_x - a_x) : 12'(a_x - b_x);
         dy_ff <= (b_y >= a_y) ? 12'(b_y - a_y) : 12'(a_y - b_y);
         err_ff <= ((b_x >= a_x) ? 12'(b_x - a_x) : 12'(a_x - b_x))
                 - ((b_y >= a_y) ? 12'(b_y - a_y) : 12'(a_y - b_y));
         sx_ff <= (a_x < b_x);
         sy_ff <= (a_y < b_y);
      end else if (cmd.line_step) begin
         logic signed [11:0] er;
         er = err_ff;
         if (e2 > -13'(dy_ff)) begin
            er = er - dy_ff;
            x_ff <= sx_ff ? x_ff + 12'sd1 : x_ff - 12'sd1;
         end
         if (e2 < 13'(dx_ff)) begin
            er = er + dx_ff;
            y_ff <= sy_ff ? y_ff + 12'sd1 : y_ff - 12'sd1;
         end
         err_ff <= er;
      end
   end
   assign sts.line_done = (x_ff == x1_ff) && (y_ff == y1_ff);

   // Fill scan.
   logic [9:0] cx1, cy1;
   assign cx1 = (req_ff.end_x >= ew) ? ew - 10'd1 : req_ff.end_x;
   assign cy1 = (req_ff.end_y >= eh) ? eh - 10'd1 : req_ff.end_y;
   always_ff @(posedge clock) begin
      if (cmd.fill_init) begin
         fx_ff <= req_ff.start_x; fy_ff <= req_ff.start_y;
         fx0_ff <= req_ff.start_x; fx1_ff <= cx1; fy1_ff <= cy1;
      end else if (cmd.fill_step) begin
         if (fx_ff == fx1_ff) begin
            fx_ff <= fx0_ff;
            fy_ff <= fy_ff + 10'd1;
         end else begin
            fx_ff <= fx_ff + 10'd1;
         end
      end
   end
   assign sts.fill_empty = (ew == 10'd0) || (eh == 10'd0)
                         || (req_ff.start_x > cx1) || (req_ff.start_y > cy1);
   assign sts.fill_done = (fx_ff == fx1_ff) && (fy_ff == fy1_ff);

   // Clear sweep.
   logic [AW:0] csize;
   assign csize = (AW+1)'(rbytes) * (AW+1)'(eh);
   always_ff @(posedge clock) begin
      if (cmd.clr_init) begin
         cidx_ff <= '0;
         csize_ff <= csize;
      end else if (cmd.clr_step) begin
         cidx_ff <= cidx_ff + 1'b1;
      end
   end
   assign sts.clr_empty = (csize == '0) || (req_ff.paint > PAINT_MAXV);
   assign sts.clr_done = (cidx_ff + 1'b1 == csize_ff);

   // Reset sweep over every byte of both planes.
   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_ff <= '0;
      end else if (cmd.wipe_step) begin
         wipe_ff <= wipe_ff + 1'b1;
      end
   end
   assign sts.wipe_done = (wipe_ff == AW'(tfde_pkg::PlaneDepth - 1));

   // Pixel source selection.
   always_comb begin
      pv = 1'b0; px = '0; py = '0;
      ppaint = req_ff.paint;
      if (cmd.line_step) begin
         pv = !x_ff[11] && !y_ff[11] && !x_ff[10] && !y_ff[10];
         px = x_ff[9:0]; py = y_ff[9:0];
      end else if (cmd.fill_step) begin
         pv = 1'b1; px = fx_ff; py = fy_ff;
      end else if (cmd.plot_pt || cmd.get_issue) begin
         pv = 1'b1; px = req_ff.start_x; py = req_ff.start_y;
      end
   end

   // Locate stage: byte address and bit mask.
   logic       on_panel;
   logic [9:0] ry;
   logic [AW-1:0] paddr;
   assign on_panel = (px < ew) && (py < eh);
   assign ry = csr_flip ? (eh - 10'd1 - py) : py;
   assign paddr = AW'(ry * rbytes + 17'(px >> 3));

   logic            s1_v_ff, s1_get_ff;
   logic [AW-1:0]   s1_a_ff;
   logic [7:0]      s1_m_ff;
   logic [1:0]      s1_p_ff;
   logic            s2_v_ff, s2_get_ff;
   logic [AW-1:0]   s2_a_ff;
   logic [7:0]      s2_m_ff;
   logic [1:0]      s2_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0; s2_v_ff <= 1'b0;
         s1_get_ff <= 1'b0; s2_get_ff <= 1'b0;
      end else begin
         s1_v_ff <= pv && on_panel && (cmd.get_issue || ppaint <= PAINT_MAXV);
         s1_get_ff <= cmd.get_issue;
         s2_v_ff <= s1_v_ff;
         s2_get_ff <= s1_get_ff;
      end
      s1_a_ff <= paddr;
      s1_m_ff <= 8'h80 >> px[2:0];
      s1_p_ff <= ppaint;
      s2_a_ff <= s1_a_ff; s2_m_ff <= s1_m_ff; s2_p_ff <= s1_p_ff;
   end
   assign sts.rmw_busy = s1_v_ff || s2_v_ff || s1_get_ff || s2_get_ff;

   // Planes: reset clears them with a sweep; valid-free, controller waits.
   logic [7:0] mono_mem [tfde_pkg::PlaneDepth];
   logic [7:0] red_mem  [tfde_pkg::PlaneDepth];
   logic [7:0] mono_rd_ff, red_rd_ff;

   logic       wr_en;
   logic [AW-1:0] wr_a;
   logic [7:0] wr_m, wr_r;
   logic       wr_red;
   always_comb begin
      wr_en = 1'b0; wr_a = s2_a_ff; wr_m = mono_rd_ff; wr_r = red_rd_ff; wr_red = csr_red;
      if (cmd.wipe_step) begin
         wr_en = 1'b1; wr_a = wipe_ff;
         wr_m = 8'hFF; wr_r = 8'h00; wr_red = 1'b1;
      end else if (cmd.clr_step) begin
         wr_en = 1'b1; wr_a = cidx_ff[AW-1:0];
         wr_m = (req_ff.paint == tfde_pkg::PAINT_BLACK) ? 8'h00 : 8'hFF;
         wr_r = (req_ff.paint == tfde_pkg::PAINT_RED) ? 8'hFF : 8'h00;
      end else if (s2_v_ff && !s2_get_ff) begin
         wr_en = 1'b1;
         wr_m = (s2_p_ff != tfde_pkg::PAINT_BLACK) ? (mono_rd_ff | s2_m_ff)
                                                 : (mono_rd_ff & ~s2_m_ff);
         wr_r = (s2_p_ff == tfde_pkg::PAINT_RED) ? (red_rd_ff | s2_m_ff)
                                               : (red_rd_ff & ~s2_m_ff);
      end
   end

   always_ff @(posedge clock) begin
      mono_rd_ff <= mono_mem[s1_a_ff];
      red_rd_ff  <= red_mem[s1_a_ff];
      if (wr_en) begin
         mono_mem[wr_a] <= wr_m;
         if (wr_red) red_mem[wr_a] <= wr_r;
      end
   end

   always_comb begin
      get_color = 2'd0;
      if (s2_v_ff && s2_get_ff) begin
         if (csr_red && (red_rd_ff & s2_m_ff) != 8'h00) get_color = 2'd2;
         else if ((mono_rd_ff & s2_m_ff) == 8'h00) get_color = 2'd1;
      end
   end
endmodule

@@ src/tfde_controller.sv @@
// Controller state machine sequencing commands through the datapath.
module tfde_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           op,
   input  tfde_pkg::dp_sts_type sts,
   output tfde_pkg::dp_cmd_type cmd,
   output logic                 busy,
   output logic                 done,
   output logic                 is_get
);
   typedef enum logic [8:0] {
      ST_INIT  = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_DISP  = 9'b000000100,
      ST_SEG   = 9'b000001000,
      ST_LINE  = 9'b000010000,
      ST_FILL  = 9'b000100000,
      ST_CLR   = 9'b001000000,
      ST_DRAIN = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] seg_ff, seg_in;
   logic [2:0] op_ff;
   logic [3:0] drain_ff, drain_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         seg_ff <= '0;
         drain_ff <= '0;
         op_ff <= '0;
      end else begin
         state_ff <= state_in;
         seg_ff <= seg_in;
         drain_ff <= drain_in;
         if (start && state_ff == ST_IDLE) op_ff <= op;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign is_get = (op_ff == tfde_pkg::OP_GET);

   always_comb begin
      state_in = state_ff;
      seg_in = seg_ff;
      drain_in = drain_ff;
      cmd = '0;
      cmd.seg_sel = seg_ff;
      done = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            // Sweep both planes to white once after reset.
            cmd.wipe_step = 1'b1;
            if (sts.wipe_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load_cmd = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            seg_in = '0;
            drain_in = '0;
            cmd.seg_sel = 2'd0;
            case (op_ff)
               tfde_pkg::OP_SET: begin cmd.plot_pt = 1'b1; state_in = ST_DRAIN; end
               tfde_pkg::OP_GET: begin cmd.get_issue = 1'b1; state_in = ST_DRAIN; end
               tfde_pkg::OP_FILL: begin
                  cmd.fill_init = 1'b1;
                  state_in = sts.fill_empty ? ST_DONE : ST_FILL;
               end
               tfde_pkg::OP_LINE, tfde_pkg::OP_RECT: begin
                  cmd.seg_load = 1'b1; state_in = ST_LINE;
               end
               tfde_pkg::OP_CLEAR: begin
                  cmd.clr_init = 1'b1;
                  state_in = sts.clr_empty ? ST_DONE : ST_CLR;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SEG: begin
            // Wait for writes of the previous segment to land.
            if (!sts.rmw_busy) begin
               cmd.seg_load = 1'b1;
               state_in = ST_LINE;
            end
         end
         ST_LINE: begin
            // Each pixel is a read-modify-write; issue one only when the drain_ff
            // spacing counter wraps, so no two updates of the same byte overlap.
            drain_in = drain_ff + 4'd1;
            if (drain_ff == 4'd2) begin
               drain_in = '0;
               cmd.line_step = 1'b1;
               if (sts.line_done) begin
                  if (op_ff == tfde_pkg::OP_RECT && seg_ff != 2'd3) begin
                     seg_in = seg_ff + 2'd1;
                     state_in = ST_SEG;
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_FILL: begin
            drain_in = drain_ff + 4'd1;
            if (drain_ff == 4'd2) begin
               drain_in = '0;
               cmd.fill_step = 1'b1;
               if (sts.fill_done) state_in = ST_DRAIN;
            end
         end
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = ST_DONE;
         end
         ST_DRAIN: begin
            drain_in = '0;
            if (!sts.rmw_busy) state_in = ST_DONE;
            else if (is_get && drain_ff == 4'd0) state_in = ST_DRAIN;
         end
         ST_DONE: begin
            done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

@@ src/tricolor_framebuffer_draw_engine_top.sv @@
// Top level of the tricolor framebuffer draw engine.
// The engine takes one drawing command per transaction when start is high and
// busy is low, and answers every command with exactly one result, shown for a
// single cycle with rsp_valid; the receiver cannot stall it. After reset the
// engine keeps busy high while it sweeps both planes to white, one byte per
// cycle. A set or get locates the pixel's byte and bit and reads that byte; a
// set on the panel writes it back modified, and the answer waits until the
// pipeline has drained. A line or fill spaces its pixels apart, since each is a
// read-modify-write of a plane byte and no two updates of one byte may overlap;
// a clear writes one byte of the visible area per cycle. Configuration is to be
// written through the csr_ port while the engine is idle; nothing enforces it.
module tricolor_framebuffer_draw_engine_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tfde_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output tfde_pkg::rsp_type    rsp_data,
   input  logic                 csr_we,
   input  logic [tfde_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [tfde_pkg::CsrDataW-1:0] csr_data
);
   logic [9:0] width_ff, height_ff;
   logic       flip_ff, red_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 10'd400;
         height_ff <= 10'd300;
         flip_ff <= 1'b0;
         red_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            tfde_pkg::CSR_WIDTH:  width_ff <= csr_data;
            tfde_pkg::CSR_HEIGHT: height_ff <= csr_data;
            tfde_pkg::CSR_FLIP:   flip_ff <= csr_data[0];
            tfde_pkg::CSR_RED:    red_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   tfde_pkg::dp_cmd_type cmd;
   tfde_pkg::dp_sts_type sts;
   logic [1:0] color;
   logic [1:0] color_ff;
   logic done, is_get;

   tfde_datapath u_dp (
      .clock, .reset, .req_in(req_data),
      .csr_w(width_ff), .csr_h(height_ff), .csr_flip(flip_ff), .csr_red(red_ff),
      .cmd, .sts, .get_color(color)
   );

   tfde_controller u_ctl (
      .clock, .reset, .start, .op(req_data.operation), .sts, .cmd,
      .busy, .done, .is_get
   );

   // Hold the readback color captured when the read data returns.
   always_ff @(posedge clock) begin
      if (sts.rmw_busy) color_ff <= color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= done;
      end
      rsp_data.read_color <= is_get ? color_ff : 2'd0;
      rsp_data.was_read <= is_get;
   end
endmodule
